>>> design/isd_pkg.sv
// Package for the single-to-double decode unit: class codes, field widths
// and the result struct. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package isd_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned DblW   = 64;
  localparam int unsigned ClassW = 3;

  localparam logic [ClassW-1:0] ClassZero   = 3'd0;
  localparam logic [ClassW-1:0] ClassDenorm = 3'd1;
  localparam logic [ClassW-1:0] ClassNormal = 3'd2;
  localparam logic [ClassW-1:0] ClassInf    = 3'd3;
  localparam logic [ClassW-1:0] ClassNan    = 3'd4;

  localparam logic [DblW-2:0] DblMaxMag = 63'h7FEF_FFFF_FFFF_FFFF;
  localparam logic [10:0] RebiasNormal  = 11'd896;
  localparam logic [10:0] RebiasDenorm  = 11'd874;

  typedef struct packed {
    logic [DblW-1:0]   bits;
    logic [ClassW-1:0] cls;
  } result_t;

endpackage
`default_nettype wire

>>> design/ieee_single_to_double_decode_unit.sv
// Top level of the single-to-double decode unit: APB register, input
// register, conversion logic and result register. Depends on isd_pkg, isd_convert.
`timescale 1ns / 1ps
`default_nettype none
// Converts a stream of raw 32-bit words holding IEEE-754 singles into double
// bit patterns plus a class code. Each request passes the input register, then
// the result register; one is accepted every cycle unless a result stall backs
// up to the input. The conversion is one pass of logic between the registers.
// NaNs map to the largest finite double, infinities to it signed, negative zero to zero.
// Register byte_order at address 0 (reset 1 = big-endian).
module ieee_single_to_double_decode_unit (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [1:0]                 paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready,
  input  wire logic                       raw_word_valid_i,
  output logic                            raw_word_stall_o,
  input  wire logic [isd_pkg::WordW-1:0]  raw_word_i,
  output logic                            result_valid_o,
  input  wire logic                       result_stall_i,
  output logic [isd_pkg::DblW-1:0]        double_bits_o,
  output logic [isd_pkg::ClassW-1:0]      value_class_o
);

  logic byte_order_q;
  logic in_valid_q;
  logic [isd_pkg::WordW-1:0] in_word_q;
  logic out_valid_q;
  isd_pkg::result_t res_d, res_q;
  logic out_adv, in_adv;

  // Configuration register.
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {31'd0, byte_order_q} : 32'd0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_order_q <= 1'b1;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      byte_order_q <= pwdata[0];
    end
  end

  // Pipeline flow: each stage advances when the next one is free.
  assign out_adv = !out_valid_q || !result_stall_i;
  assign in_adv  = !in_valid_q || out_adv;
  assign raw_word_stall_o = !in_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_adv) in_valid_q <= raw_word_valid_i;
      if (out_adv) out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && raw_word_valid_i) in_word_q <= raw_word_i;
    if (out_adv && in_valid_q) res_q <= res_d;
  end

  isd_convert u_convert (
    .byte_order_i(byte_order_q),
    .word_i      (in_word_q),
    .result_o    (res_d)
  );

  assign result_valid_o = out_valid_q;
  assign double_bits_o  = res_q.bits;
  assign value_class_o  = res_q.cls;

`ifndef NO_ASSERTIONS
  // A stalled result stays valid.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && result_stall_i |=> out_valid_q) else $error("result dropped");
  // Input stalls only when both stages are full.
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    raw_word_stall_o |-> in_valid_q && out_valid_q) else $error("spurious stall");
  // A held input item moves to the output once it frees.
  a_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_adv |=> out_valid_q) else $error("item lost");
`endif

endmodule
`default_nettype wire

>>> design/isd_convert.sv
// Combinational binary32 to binary64 conversion with byte-order select.
// Depends on isd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module isd_convert (
  input  wire logic                      byte_order_i,
  input  wire logic [isd_pkg::WordW-1:0] word_i,
  output isd_pkg::result_t               result_o
);

  logic [31:0] src;
  logic        sgn;
  logic [7:0]  e;
  logic [22:0] f;
  logic [4:0]  p;
  logic [51:0] frac;

  // Byte order: big-endian passes through, little-endian swaps bytes.
  assign src = byte_order_i ? word_i : {word_i[7:0], word_i[15:8], word_i[23:16], word_i[31:24]};
  assign sgn = src[31];
  assign e   = src[30:23];
  assign f   = src[22:0];

  // Leading-one position of the denormal fraction (priority encoder).
  always_comb begin
    p = 5'd0;
    for (int i = 0; i < 23; i++) begin
      if (f[i]) p = 5'(i);
    end
  end

  // Drop the leading one and left-justify the rest in the 52-bit field.
  assign frac = {f, 29'd0} << (6'd23 - {1'b0, p});

  // Classify and assemble.
  always_comb begin
    result_o.bits = '0;
    result_o.cls  = isd_pkg::ClassZero;
    if (e == 8'hFF) begin
      if (f != '0) begin
        result_o.bits = {1'b0, isd_pkg::DblMaxMag};
        result_o.cls  = isd_pkg::ClassNan;
      end else begin
        result_o.bits = {sgn, isd_pkg::DblMaxMag};
        result_o.cls  = isd_pkg::ClassInf;
      end
    end else if (e != 8'd0) begin
      result_o.bits = {sgn, {3'd0, e} + isd_pkg::RebiasNormal, f, 29'd0};
      result_o.cls  = isd_pkg::ClassNormal;
    end else if (f != '0) begin
      result_o.bits = {sgn, {6'd0, p} + isd_pkg::RebiasDenorm, frac};
      result_o.cls  = isd_pkg::ClassDenorm;
    end
  end

endmodule
`default_nettype wire

>>> tb/sv/tb_ieee_single_to_double_decode_unit.sv
// Testbench for the single-to-double decode unit: drives raw words through the
// request channel, predicts each double and class code, checks the results.
// Depends on isd_pkg and ieee_single_to_double_decode_unit.
`timescale 1ns / 1ps
module tb_ieee_single_to_double_decode_unit;

  localparam logic [1:0] AddrByteOrder = 2'd0;
  localparam int unsigned IdleLimit = 5000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic raw_word_valid_i = 1'b0;
  logic raw_word_stall_o;
  logic [isd_pkg::WordW-1:0] raw_word_i = '0;
  logic result_valid_o;
  logic result_stall_i = 1'b0;
  logic [isd_pkg::DblW-1:0] double_bits_o;
  logic [isd_pkg::ClassW-1:0] value_class_o;

  logic big_endian = 1'b1;
  isd_pkg::result_t pending_doubles[$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_mode = 0;

  ieee_single_to_double_decode_unit dut (.*);

  initial forever #5 clk_i = ~clk_i;

  // Expected conversion of one raw word under the current byte order.
  function automatic isd_pkg::result_t convert_single(input logic [31:0] word);
    logic [31:0] s;
    logic [7:0] e;
    logic [22:0] f;
    logic [63:0] sgn;
    int p;
    isd_pkg::result_t r;
    s = big_endian ? word : {word[7:0], word[15:8], word[23:16], word[31:24]};
    sgn = {s[31], 63'd0};
    e = s[30:23];
    f = s[22:0];
    if (e == 8'hFF) begin
      if (f != 0) begin
        r.bits = {1'b0, isd_pkg::DblMaxMag};
        r.cls = isd_pkg::ClassNan;
      end else begin
        r.bits = sgn | {1'b0, isd_pkg::DblMaxMag};
        r.cls = isd_pkg::ClassInf;
      end
    end else if (e != 0) begin
      r.bits = sgn | (64'(e + 11'd896) << 52) | (64'(f) << 29);
      r.cls = isd_pkg::ClassNormal;
    end else if (f != 0) begin
      p = 22;
      while (f[p] == 1'b0) p--;
      r.bits = sgn | (64'(p + 874) << 52) | ((64'(f) & ((64'd1 << p) - 1)) << (52 - p));
      r.cls = isd_pkg::ClassDenorm;
    end else begin
      r.bits = '0;
      r.cls = isd_pkg::ClassZero;
    end
    return r;
  endfunction

  // Receiver stall pattern: modes cycle between none, random and heavy.
  always @(posedge clk_i) begin
    case (stall_mode)
      0: result_stall_i <= 1'b0;
      1: result_stall_i <= ($urandom_range(0, 3) == 0);
      default: result_stall_i <= ($urandom_range(0, 3) != 0);
    endcase
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
  end

  // Result checker and idle watchdog.
  always @(posedge clk_i) begin
    isd_pkg::result_t exp_r;
    if (rst_ni) begin
      if ((result_valid_o && !result_stall_i) ||
          (raw_word_valid_i && !raw_word_stall_o)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Timeout with %0d results outstanding", pending_doubles.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
      if (result_valid_o && !result_stall_i) begin
        if (pending_doubles.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result %h", double_bits_o);
        end else begin
          exp_r = pending_doubles.pop_front();
          if (exp_r.bits !== double_bits_o || exp_r.cls !== value_class_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected %h/%0d, got %h/%0d",
                       exp_r.bits, exp_r.cls, double_bits_o, value_class_o);
          end
        end
      end
    end
  end

  // Sends one request and queues its expected result on acceptance.
  task automatic send_word(input logic [31:0] word);
    raw_word_valid_i <= 1'b1;
    raw_word_i <= word;
    do @(posedge clk_i); while (raw_word_stall_o);
    pending_doubles.push_back(convert_single(word));
  endtask

  task automatic drop_valid();
    raw_word_valid_i <= 1'b0;
  endtask

  task automatic drain();
    drop_valid();
    @(posedge clk_i);
    while (pending_doubles.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_byte_order(input logic [31:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= AddrByteOrder; pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    big_endian = value[0];
  endtask

  // Bursty sender: random word stream with gaps.
  task automatic send_burst_stream(input int unsigned count);
    int unsigned burst;
    logic [31:0] w;
    burst = 0;
    for (int unsigned i = 0; i < count; i++) begin
      if (burst == 0) begin
        drop_valid();
        repeat ($urandom_range(0, 4)) @(posedge clk_i);
        burst = $urandom_range(1, 30);
      end
      w = $urandom();
      case ($urandom_range(0, 9))
        0: w[30:23] = 8'h00;
        1: w[30:23] = 8'hFF;
        2: w = {w[31], 31'd0};
        3: w[30:0] = {8'hFF, 23'd0};
        4: w = {w[31], 8'h00, 23'(1) << $urandom_range(0, 22)};
        default: ;
      endcase
      if (!big_endian) w = {w[7:0], w[15:8], w[23:16], w[31:24]};
      send_word(w);
      burst--;
    end
  endtask

  task automatic test_directed_big_endian();
    logic [31:0] words[$];
    words = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h8000_0001,
              32'h007F_FFFF, 32'h0040_0000, 32'h0080_0000, 32'h3F80_0000,
              32'hBF80_0000, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h7F80_0000,
              32'hFF80_0000, 32'h7FC0_0000, 32'hFF80_0001, 32'h7FFF_FFFF,
              32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA};
    foreach (words[i]) send_word(words[i]);
    drain();
  endtask

  task automatic test_directed_little_endian();
    write_byte_order(32'hFFFF_FFFE);
    write_byte_order(32'h0000_0000);
    send_word(32'h0000_803F);
    send_word(32'h0000_80FF);
    send_word(32'h0100_0000);
    send_word(32'h0000_0080);
    send_word(32'h1234_5678);
    drain();
  endtask

  task automatic test_random_little_endian();
    send_burst_stream(500);
    drain();
  endtask

  task automatic test_random_big_endian();
    write_byte_order(32'h0000_0001);
    send_burst_stream(500);
    drain();
  endtask

  task automatic test_random_alternating();
    write_byte_order(32'hFFFF_FFFF);
    send_burst_stream(150);
    drain();
    write_byte_order(32'h0000_0000);
    send_burst_stream(150);
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_big_endian();
    test_directed_little_endian();
    test_random_little_endian();
    test_random_big_endian();
    test_random_alternating();
    if (mismatches == 0 && pending_doubles.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
